// ===== hw/rtl/cdq_pkg.sv =====
// cdq_pkg: operation codes, field widths and reset constants of the circular deque
// no dependencies; used by the interfaces, the top level and the checker

package cdq_pkg;

    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 7;

    localparam int CAP_RESET = 64;

    localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd4;

    localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

endpackage

// ===== hw/rtl/cdq_if.sv =====
// cdq_in_if / cdq_out_if: valid-ready channels of the circular deque
// depends on cdq_pkg for the field widths

interface cdq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [cdq_pkg::FUNC_W-1:0]           func;
    logic signed [cdq_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface cdq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 ok;
    logic signed [cdq_pkg::VALUE_W-1:0]   front_value;
    logic signed [cdq_pkg::VALUE_W-1:0]   rear_value;
    logic                                 is_empty;
    logic                                 is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

// ===== hw/rtl/cdq_ram.sv =====
// cdq_ram: ring store of the deque, one write port and one registered read port
// no dependencies

module cdq_ram #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [DATA_WIDTH-1:0]         i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    output logic [DATA_WIDTH-1:0]         o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== hw/rtl/circular_deque.sv =====
// circular_deque: double-ended queue in a ring store, capacity set by a register
// query and push results are registered and shown in the next cycle; a pop that leaves
// elements behind first passes through the read state, as it reads the new end from the store
// throughput: one push or query per cycle while the result is taken; no new request during a pop's store read
// reset (synchronous, active low) empties the deque and sets capacity to 64, or to DEPTH if smaller;
// a capacity write empties it too. depends on cdq_pkg, cdq_if and cdq_ram

module circular_deque #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cdq_in_if.sink                     i_in,
    cdq_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]  i_cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (AW + 1 > cdq_pkg::CAP_W) ? AW + 1 : cdq_pkg::CAP_W;
    localparam int RESET_LAST =
        ((cdq_pkg::CAP_RESET > DEPTH) ? DEPTH : cdq_pkg::CAP_RESET) - 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                  r_state;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         r_tail;
    logic [AW-1:0]         r_last;
    logic                  r_empty;
    logic                  r_full;
    logic                  r_ok;
    logic                  r_out_valid;
    logic                  r_pend_front;
    logic [DATA_WIDTH-1:0] r_front;
    logic [DATA_WIDTH-1:0] r_rear;

    logic [AW-1:0]         n_head;
    logic [AW-1:0]         n_tail;
    logic                  n_empty;
    logic                  n_full;
    logic                  n_ok;
    logic [DATA_WIDTH-1:0] n_front;
    logic [DATA_WIDTH-1:0] n_rear;

    logic                  accept;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  rd_front;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DATA_WIDTH-1:0] val_store;
    logic [DATA_WIDTH+cdq_pkg::VALUE_W-1:0] val_ext;
    logic [DATA_WIDTH+cdq_pkg::VALUE_W-1:0] front_ext;
    logic [DATA_WIDTH+cdq_pkg::VALUE_W-1:0] rear_ext;

    logic [AW-1:0]         head_inc;
    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         tail_inc;
    logic [AW-1:0]         tail_dec;
    logic [AW-1:0]         n_tail_inc;
    logic [CW-1:0]         cap_ext;
    logic [AW-1:0]         cap_last;

    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    assign val_ext   = {{DATA_WIDTH{1'b0}}, i_in.value};
    assign val_store = val_ext[DATA_WIDTH-1:0];

    // ring steps wrap at the last slot in use
    assign head_inc = (r_head == r_last) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? r_last : r_head - 1'b1;
    assign tail_inc = (r_tail == r_last) ? '0 : r_tail + 1'b1;
    assign tail_dec = (r_tail == '0) ? r_last : r_tail - 1'b1;

    // capacity of zero acts as one, above the built depth as the depth
    always_comb begin
        cap_ext = CW'(i_cfg_wdata);
        if (cap_ext == '0) begin
            cap_last = '0;
        end else if (cap_ext > CW'(DEPTH)) begin
            cap_last = AW'(DEPTH - 1);
        end else begin
            cap_last = AW'(cap_ext - 1'b1);
        end
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_front  = r_front;
        n_rear   = r_rear;
        n_ok     = 1'b1;
        wr_en    = 1'b0;
        wr_addr  = '0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        rd_front = 1'b0;
        unique case (i_in.func) inside
            cdq_pkg::FUNC_PUSH_FRONT, cdq_pkg::FUNC_PUSH_BACK: begin
                if (r_full) begin
                    n_ok = 1'b0;
                end else if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    n_front = val_store;
                    n_rear  = val_store;
                end else if (i_in.func == cdq_pkg::FUNC_PUSH_FRONT) begin
                    n_head  = head_dec;
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                    n_front = val_store;
                end else begin
                    n_tail  = tail_inc;
                    wr_en   = 1'b1;
                    wr_addr = tail_inc;
                    n_rear  = val_store;
                end
            end
            cdq_pkg::FUNC_POP_FRONT, cdq_pkg::FUNC_POP_BACK: begin
                if (r_empty) begin
                    n_ok = 1'b0;
                end else if (r_head == r_tail) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b1;
                end else if (i_in.func == cdq_pkg::FUNC_POP_FRONT) begin
                    n_head   = head_inc;
                    rd_en    = 1'b1;
                    rd_addr  = head_inc;
                    rd_front = 1'b1;
                end else begin
                    n_tail  = tail_dec;
                    rd_en   = 1'b1;
                    rd_addr = tail_dec;
                end
            end
            default: begin
            end
        endcase
        n_tail_inc = (n_tail == r_last) ? '0 : n_tail + 1'b1;
        n_full     = !n_empty && (n_tail_inc == n_head);
    end

    cdq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept && wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (val_store),
        .i_rd_en   (accept && rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_last      <= AW'(RESET_LAST);
            r_empty     <= 1'b1;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_we) begin
            r_last  <= cap_last;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_full  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_head  <= n_head;
                        r_tail  <= n_tail;
                        r_empty <= n_empty;
                        r_full  <= n_full;
                        if (rd_en) begin
                            r_state     <= ST_READ;
                            r_out_valid <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end else if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_READ: begin
                    r_state     <= ST_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload: cached end values and the result flag
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && accept) begin
            r_front      <= n_front;
            r_rear       <= n_rear;
            r_ok         <= n_ok;
            r_pend_front <= rd_front;
        end else if (r_state == ST_READ) begin
            if (r_pend_front) begin
                r_front <= rd_data;
            end else begin
                r_rear <= rd_data;
            end
        end
    end

    assign front_ext = {{cdq_pkg::VALUE_W{1'b0}}, r_front};
    assign rear_ext  = {{cdq_pkg::VALUE_W{1'b0}}, r_rear};

    assign o_out.valid       = r_out_valid;
    assign o_out.ok          = r_ok;
    assign o_out.is_empty    = r_empty;
    assign o_out.is_full     = r_full;
    assign o_out.front_value = r_empty ? cdq_pkg::EMPTY_VALUE
                                       : front_ext[cdq_pkg::VALUE_W-1:0];
    assign o_out.rear_value  = r_empty ? cdq_pkg::EMPTY_VALUE
                                       : rear_ext[cdq_pkg::VALUE_W-1:0];

endmodule

// ===== hw/rtl/cdq_chk.sv =====
// cdq_chk: port-level checks on the result channel of circular_deque
// depends on cdq_pkg; bound to circular_deque at the end of this file

module cdq_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_ok,
    input logic [cdq_pkg::VALUE_W-1:0]   i_front_value,
    input logic [cdq_pkg::VALUE_W-1:0]   i_rear_value,
    input logic                          i_is_empty,
    input logic                          i_is_full
);

    // an empty deque shows -1 at both ends
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_empty |->
            i_front_value == cdq_pkg::EMPTY_VALUE && i_rear_value == cdq_pkg::EMPTY_VALUE)
        else $error("empty deque with end values other than -1");

    a_empty_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_is_empty && i_is_full))
        else $error("deque flagged both empty and full");

    // a refused operation is a push when full or a pop when empty
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ok |-> i_is_full || i_is_empty)
        else $error("refused transaction on a deque neither full nor empty");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_front_value) && $stable(i_rear_value) && $stable(i_ok))
        else $error("stalled result changed");

endmodule

bind circular_deque cdq_chk u_cdq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_ok          (o_out.ok),
    .i_front_value (o_out.front_value),
    .i_rear_value  (o_out.rear_value),
    .i_is_empty    (o_out.is_empty),
    .i_is_full     (o_out.is_full)
);

// ===== test/circular_deque_test.sv =====
`timescale 1ns / 1ps
// circular_deque_test: self-checking bench for the circular deque, with a directed table
// followed by fill/drain random traffic, checked against the table or a deque model
// depends on cdq_pkg, cdq_in_if/cdq_out_if and the circular_deque rtl

module circular_deque_test;

    localparam int DQ_DEPTH     = 64;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int STALL_PCT    = 16;

    // func codes with no operation behind them, treated as a query
    localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic                        ok;
        logic [cdq_pkg::VALUE_W-1:0] front_value;
        logic [cdq_pkg::VALUE_W-1:0] rear_value;
        logic                        is_empty;
        logic                        is_full;
    } t_deque_result;

    typedef struct {
        bit                          is_cfg;
        logic [cdq_pkg::FUNC_W-1:0]  func;
        logic [cdq_pkg::VALUE_W-1:0] value;
        bit                          typed;
        t_deque_result               want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [cdq_pkg::CAP_W-1:0] i_cfg_wdata;

    cdq_in_if  in_ch ();
    cdq_out_if out_ch ();

    circular_deque #(.DEPTH(DQ_DEPTH), .DATA_WIDTH(cdq_pkg::VALUE_W)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // behavioural deque
    logic [cdq_pkg::VALUE_W-1:0] ring_mem [DQ_DEPTH];
    int unsigned                 head_ptr;
    int unsigned                 tail_ptr;
    bit                          dq_empty;
    logic [cdq_pkg::CAP_W-1:0]   cap_reg;

    t_deque_result result_q [$];
    t_stim_row     dir_rows [$];
    bit            row_typed;
    t_deque_result row_want;
    bit            steady;

    int issued_count;
    int checked_count;
    int mismatch_count;
    int refused_count;
    int full_count;
    int cfg_writes;
    int random_count;
    int cycle_count;

    function automatic int unsigned cap_eff();
        if (cap_reg == 0) return 1;
        if (cap_reg > DQ_DEPTH) return DQ_DEPTH;
        return 32'(cap_reg);
    endfunction

    function automatic int unsigned next_slot(input int unsigned i);
        return (i + 1 >= cap_eff()) ? 0 : i + 1;
    endfunction

    function automatic int unsigned prev_slot(input int unsigned i);
        return (i == 0 || i >= cap_eff()) ? cap_eff() - 1 : i - 1;
    endfunction

    function automatic bit deque_full();
        return !dq_empty && next_slot(tail_ptr) == head_ptr;
    endfunction

    function automatic t_deque_result deque_step(input logic [cdq_pkg::FUNC_W-1:0] f,
                                                 input logic [cdq_pkg::VALUE_W-1:0] v);
        t_deque_result r;
        r.ok = 1'b1;
        case (f) inside
            cdq_pkg::FUNC_PUSH_FRONT, cdq_pkg::FUNC_PUSH_BACK: begin
                if (deque_full()) begin
                    r.ok = 1'b0;
                end else if (dq_empty) begin
                    head_ptr = 0;
                    tail_ptr = 0;
                    dq_empty = 1'b0;
                    ring_mem[0] = v;
                end else if (f == cdq_pkg::FUNC_PUSH_FRONT) begin
                    head_ptr = prev_slot(head_ptr);
                    ring_mem[head_ptr] = v;
                end else begin
                    tail_ptr = next_slot(tail_ptr);
                    ring_mem[tail_ptr] = v;
                end
            end
            cdq_pkg::FUNC_POP_FRONT, cdq_pkg::FUNC_POP_BACK: begin
                if (dq_empty) begin
                    r.ok = 1'b0;
                end else if (head_ptr == tail_ptr) begin
                    head_ptr = 0;
                    tail_ptr = 0;
                    dq_empty = 1'b1;
                end else if (f == cdq_pkg::FUNC_POP_FRONT) begin
                    head_ptr = next_slot(head_ptr);
                end else begin
                    tail_ptr = prev_slot(tail_ptr);
                end
            end
            default: ;
        endcase
        r.front_value = dq_empty ? cdq_pkg::EMPTY_VALUE : ring_mem[head_ptr];
        r.rear_value  = dq_empty ? cdq_pkg::EMPTY_VALUE : ring_mem[tail_ptr];
        r.is_empty    = dq_empty;
        r.is_full     = deque_full();
        return r;
    endfunction

    // predicts on every accepted transaction and checks every returned one
    always @(posedge i_clk) begin : track_deque
        t_deque_result want;
        t_deque_result got;
        if (!i_rst_n) begin
            head_ptr = 0;
            tail_ptr = 0;
            dq_empty = 1'b1;
            cap_reg  = cdq_pkg::CAP_W'(cdq_pkg::CAP_RESET);
        end else begin
            if (i_cfg_we) begin
                cap_reg  = i_cfg_wdata;
                head_ptr = 0;
                tail_ptr = 0;
                dq_empty = 1'b1;
            end
            if (in_ch.valid && in_ch.ready) begin
                want = deque_step(in_ch.func, in_ch.value);
                if (row_typed) want = row_want;
                if (!want.ok) refused_count++;
                if (want.is_full) full_count++;
                result_q.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.ok          = out_ch.ok;
                got.front_value = out_ch.front_value;
                got.rear_value  = out_ch.rear_value;
                got.is_empty    = out_ch.is_empty;
                got.is_full     = out_ch.is_full;
                if (result_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result: ok=%0b front=%h rear=%h empty=%0b full=%0b",
                                 got.ok, got.front_value, got.rear_value, got.is_empty,
                                 got.is_full);
                    mismatch_count++;
                end else begin
                    want = result_q.pop_front();
                    if (got.ok !== want.ok || got.front_value !== want.front_value ||
                        got.rear_value !== want.rear_value || got.is_empty !== want.is_empty ||
                        got.is_full !== want.is_full) begin
                        if (mismatch_count < 10) begin
                            $display("result %0d: expected ok=%0b front=%h rear=%h empty=%0b full=%0b",
                                     checked_count, want.ok, want.front_value, want.rear_value,
                                     want.is_empty, want.is_full);
                            $display("result %0d:      got ok=%0b front=%h rear=%h empty=%0b full=%0b",
                                     checked_count, got.ok, got.front_value, got.rear_value,
                                     got.is_empty, got.is_full);
                        end
                        mismatch_count++;
                    end
                    checked_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d of %0d results back",
                     cycle_count, checked_count, issued_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void add_step(input logic [cdq_pkg::FUNC_W-1:0] f,
                                     input logic [cdq_pkg::VALUE_W-1:0] v);
        t_stim_row row;
        row = '{1'b0, f, v, 1'b0, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [cdq_pkg::FUNC_W-1:0] f,
                                        input logic [cdq_pkg::VALUE_W-1:0] v,
                                        input logic ok, input logic [cdq_pkg::VALUE_W-1:0] fr,
                                        input logic [cdq_pkg::VALUE_W-1:0] rr, input logic e,
                                        input logic fl);
        t_stim_row row;
        row = '{1'b0, f, v, 1'b1, '{ok, fr, rr, e, fl}};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cap(input logic [cdq_pkg::CAP_W-1:0] c);
        t_stim_row row;
        row = '{1'b1, cdq_pkg::FUNC_QUERY, cdq_pkg::VALUE_W'(c), 1'b0, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic logic [cdq_pkg::VALUE_W-1:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '1;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_op(input logic [cdq_pkg::FUNC_W-1:0] f,
                           input logic [cdq_pkg::VALUE_W-1:0] v,
                           input bit typed, input t_deque_result want);
        while (!steady && $urandom_range(99) < STALL_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= f;
        in_ch.value <= v;
        row_typed   <= typed;
        row_want    <= want;
        do @(posedge i_clk); while (!in_ch.ready);
        issued_count++;
    endtask

    // capacity is only written once every outstanding transaction has come back
    task automatic set_capacity(input logic [cdq_pkg::CAP_W-1:0] c);
        in_ch.valid <= 1'b0;
        while (checked_count != issued_count) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    int caps_plan [13] = '{1, 3, 0, 2, 127, 8, 64, 65, 5, 17, 33, 63, 4};

    initial begin : stimulus
        t_deque_result none;
        t_stim_row     row;
        logic [cdq_pkg::CAP_W-1:0]  c;
        logic [cdq_pkg::FUNC_W-1:0] f;
        int  phase;
        int  ceff;
        int  run_left;
        int  r;
        int  pick;
        bit  filling;
        bit  push_it;

        none         = '0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        in_ch.valid  = 1'b0;
        in_ch.func   = cdq_pkg::FUNC_QUERY;
        in_ch.value  = '0;
        row_typed    = 1'b0;
        row_want     = '0;
        steady       = 1'b0;

        // empty deque at reset capacity, refusals, spare codes and extreme words
        add_checked(cdq_pkg::FUNC_QUERY, '0, 1'b1, cdq_pkg::EMPTY_VALUE,
                    cdq_pkg::EMPTY_VALUE, 1'b1, 1'b0);
        add_checked(cdq_pkg::FUNC_POP_FRONT, '0, 1'b0, cdq_pkg::EMPTY_VALUE,
                    cdq_pkg::EMPTY_VALUE, 1'b1, 1'b0);
        add_checked(cdq_pkg::FUNC_POP_BACK, '1, 1'b0, cdq_pkg::EMPTY_VALUE,
                    cdq_pkg::EMPTY_VALUE, 1'b1, 1'b0);
        add_checked(FUNC_SPARE_LO, 32'd123, 1'b1, cdq_pkg::EMPTY_VALUE,
                    cdq_pkg::EMPTY_VALUE, 1'b1, 1'b0);
        add_checked(FUNC_SPARE_MID, '1, 1'b1, cdq_pkg::EMPTY_VALUE,
                    cdq_pkg::EMPTY_VALUE, 1'b1, 1'b0);
        add_checked(FUNC_SPARE_HI, '0, 1'b1, cdq_pkg::EMPTY_VALUE,
                    cdq_pkg::EMPTY_VALUE, 1'b1, 1'b0);
        add_checked(cdq_pkg::FUNC_PUSH_BACK, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff,
                    32'h7fff_ffff, 1'b0, 1'b0);
        add_checked(cdq_pkg::FUNC_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h8000_0000,
                    32'h7fff_ffff, 1'b0, 1'b0);
        add_step(cdq_pkg::FUNC_PUSH_BACK, '1);
        add_step(cdq_pkg::FUNC_PUSH_FRONT, '0);
        add_step(cdq_pkg::FUNC_POP_BACK, '0);
        add_step(cdq_pkg::FUNC_POP_FRONT, '0);
        add_step(cdq_pkg::FUNC_POP_FRONT, '0);
        add_checked(cdq_pkg::FUNC_POP_BACK, '0, 1'b1, cdq_pkg::EMPTY_VALUE,
                    cdq_pkg::EMPTY_VALUE, 1'b1, 1'b0);
        // single-entry ring: full after one push
        add_cap(7'd1);
        add_checked(cdq_pkg::FUNC_PUSH_FRONT, 32'h5555_5555, 1'b1, 32'h5555_5555,
                    32'h5555_5555, 1'b0, 1'b1);
        add_checked(cdq_pkg::FUNC_PUSH_BACK, 32'haaaa_aaaa, 1'b0, 32'h5555_5555,
                    32'h5555_5555, 1'b0, 1'b1);
        add_checked(cdq_pkg::FUNC_POP_BACK, '0, 1'b1, cdq_pkg::EMPTY_VALUE,
                    cdq_pkg::EMPTY_VALUE, 1'b1, 1'b0);
        // zero capacity behaves as one
        add_cap(7'd0);
        add_checked(cdq_pkg::FUNC_PUSH_BACK, 32'd1, 1'b1, 32'd1, 32'd1, 1'b0, 1'b1);
        add_checked(cdq_pkg::FUNC_PUSH_FRONT, 32'd2, 1'b0, 32'd1, 32'd1, 1'b0, 1'b1);
        // oversize capacity clamps, and the write empties the deque
        add_cap(7'd127);
        add_checked(cdq_pkg::FUNC_QUERY, '0, 1'b1, cdq_pkg::EMPTY_VALUE,
                    cdq_pkg::EMPTY_VALUE, 1'b1, 1'b0);
        add_cap(7'd2);
        add_step(cdq_pkg::FUNC_PUSH_FRONT, 32'h0000_ffff);
        add_step(cdq_pkg::FUNC_PUSH_FRONT, 32'hffff_0000);
        add_checked(cdq_pkg::FUNC_PUSH_BACK, 32'd3, 1'b0, 32'hffff_0000, 32'h0000_ffff,
                    1'b0, 1'b1);
        add_step(cdq_pkg::FUNC_POP_FRONT, '0);
        add_step(cdq_pkg::FUNC_POP_FRONT, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int idx = 0; idx < dir_rows.size(); idx++) begin
            row = dir_rows[idx];
            if (row.is_cfg) begin
                set_capacity(row.value[cdq_pkg::CAP_W-1:0]);
            end else begin
                send_op(row.func, row.value, row.typed, row.want);
            end
        end

        // random phases: alternate fill-biased and drain-biased runs at each capacity
        phase = 0;
        while (random_count < RANDOM_ITEMS) begin
            if (phase < $size(caps_plan)) pick = caps_plan[phase];
            else pick = $urandom_range(DQ_DEPTH, 1);
            c = pick[cdq_pkg::CAP_W-1:0];
            phase++;
            set_capacity(c);
            ceff     = (c == 0) ? 1 : (c > DQ_DEPTH) ? DQ_DEPTH : int'(c);
            filling  = 1'b1;
            run_left = 2 * ceff + $urandom_range(8, 2);
            repeat (4 * ceff + 40) begin
                steady = (random_count >= 800 && random_count < 1200);
                if (run_left == 0) begin
                    filling  = !filling;
                    run_left = 2 * ceff + $urandom_range(8, 2);
                end
                run_left--;
                r = $urandom_range(99);
                if (r < 3) begin
                    f = cdq_pkg::FUNC_QUERY;
                end else if (r < 6) begin
                    pick = $urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO);
                    f    = pick[cdq_pkg::FUNC_W-1:0];
                end else begin
                    push_it = filling ? (r < 76) : (r < 36);
                    if (push_it) begin
                        f = $urandom_range(1) ? cdq_pkg::FUNC_PUSH_FRONT
                                              : cdq_pkg::FUNC_PUSH_BACK;
                    end else begin
                        f = $urandom_range(1) ? cdq_pkg::FUNC_POP_FRONT
                                              : cdq_pkg::FUNC_POP_BACK;
                    end
                end
                send_op(f, rand_word(), 1'b0, none);
                random_count++;
            end
        end
        in_ch.valid <= 1'b0;
        steady = 1'b0;

        while (checked_count != issued_count) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d operations over %0d capacity writes: %0d refused, %0d left the deque full",
                 issued_count, cfg_writes, refused_count, full_count);
        $display("%0d results checked, %0d mismatches, %0d still outstanding",
                 checked_count, mismatch_count, result_q.size());
        if (mismatch_count == 0 && result_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_if.sv
hw/rtl/cdq_ram.sv
hw/rtl/circular_deque.sv
hw/rtl/cdq_chk.sv
test/circular_deque_test.sv
